@@ hw/rtl/ssfm_pkg.sv @@
package ssfm_pkg;

    localparam int MAX_FRAMES = 32;
    localparam int ADDR_W     = 32;
    localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

    localparam logic [1:0] ACT_EVICT   = 2'd0;
    localparam logic [1:0] ACT_RESTORE = 2'd1;
    localparam logic [1:0] ACT_L2G     = 2'd2;
    localparam logic [1:0] ACT_G2L     = 2'd3;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;
    localparam logic [1:0] ERR_PTR   = 2'd3;

    localparam logic REG_SPM_BASE = 1'b0;
    localparam logic REG_MEM_BASE = 1'b1;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] stack_pointer;
        logic [ADDR_W-1:0] address;
    } t_cmd;

    typedef struct packed {
        logic              dma_issue;
        logic              dma_to_memory;
        logic [ADDR_W-1:0] dma_local_addr;
        logic [ADDR_W-1:0] dma_global_addr;
        logic [ADDR_W-1:0] dma_length;
        logic [ADDR_W-1:0] result_addr;
        logic              translated;
        logic [1:0]        error;
    } t_result;

    typedef struct packed {
        logic [ADDR_W-1:0] local_addr;
        logic [ADDR_W-1:0] global_addr;
        logic [ADDR_W-1:0] length;
    } t_frame;

    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_ctl;

    typedef struct packed {
        logic             empty;
        logic             full;
        logic [CNT_W-1:0] count;
        t_frame           top;
    } t_stack_sts;

endpackage

@@ hw/rtl/ssfm_frame_stack.sv @@
module ssfm_frame_stack (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ssfm_pkg::t_stack_ctl i_ctl,
    input  ssfm_pkg::t_frame     i_frame,
    output ssfm_pkg::t_stack_sts o_sts
);
    import ssfm_pkg::*;

    t_frame           r_mem [MAX_FRAMES];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] w_top_ptr;

    assign w_top_ptr = r_count - CNT_W'(1);

    always_comb begin
        n_count = r_count;
        if (i_ctl.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_ctl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // entries have no reset; only pushed slots are ever read
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_count[IDX_W-1:0]] <= i_frame;
        end
    end

    assign o_sts.empty = (r_count == '0);
    assign o_sts.full  = (r_count >= CNT_W'(MAX_FRAMES));
    assign o_sts.count = r_count;
    assign o_sts.top   = r_mem[w_top_ptr[IDX_W-1:0]];

endmodule

@@ hw/rtl/scratchpad_stack_frame_manager.sv @@
// An accepted command passes the command register, then the result register, to o_valid.
// Throughput: one transaction per cycle; busy is never raised, since each command
// touches only the top frame entry through one register stage and one compute stage.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// Reset (synchronous, active low) empties the frame stack and clears both base
// registers; frame entries are not cleared.
module scratchpad_stack_frame_manager (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ssfm_pkg::t_cmd    i_cmd,
    output logic              o_valid,
    output ssfm_pkg::t_result o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import ssfm_pkg::*;

    logic              r_cmd_vld;
    t_cmd              r_cmd;
    logic              r_res_vld;
    t_result           r_res;
    t_result           n_res;
    logic [ADDR_W-1:0] r_spm_base;
    logic [ADDR_W-1:0] r_mem_base;

    t_stack_ctl        w_ctl;
    t_stack_sts        w_sts;
    t_frame            w_push;
    logic              w_cfg_wr;
    logic              w_sp_ok;
    logic [ADDR_W-1:0] w_top;
    logic [ADDR_W-1:0] w_len;
    logic [ADDR_W-1:0] w_glob;
    logic [ADDR_W-1:0] w_l_off;
    logic [ADDR_W-1:0] w_g_off;

    assign busy   = 1'b0;
    assign pready = 1'b1;

    // configuration
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spm_base <= '0;
            r_mem_base <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_SPM_BASE: r_spm_base <= pwdata[ADDR_W-1:0];
                REG_MEM_BASE: r_mem_base <= pwdata[ADDR_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SPM_BASE: prdata = r_spm_base;
            REG_MEM_BASE: prdata = r_mem_base;
            default:      prdata = '0;
        endcase
    end

    // command register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_vld <= 1'b0;
        end else begin
            r_cmd_vld <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start & ~busy) begin
            r_cmd <= i_cmd;
        end
    end

    ssfm_frame_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_frame (w_push),
        .o_sts   (w_sts)
    );

    // frame top in memory: last evicted frame, else the memory stack base
    assign w_sp_ok = (r_cmd.stack_pointer <= r_spm_base);
    assign w_top   = w_sts.empty ? r_mem_base : w_sts.top.global_addr;
    assign w_len   = r_spm_base - r_cmd.stack_pointer;
    assign w_glob  = w_top - w_len;
    assign w_l_off = r_spm_base - r_cmd.address;
    assign w_g_off = w_top - r_cmd.address;

    assign w_push.local_addr  = r_cmd.stack_pointer;
    assign w_push.global_addr = w_glob;
    assign w_push.length      = w_len;

    always_comb begin
        n_res = '0;
        w_ctl = '0;
        unique case (r_cmd.action)
            ACT_EVICT: begin
                if (w_sts.full) begin
                    n_res.error = ERR_FULL;
                end else if (!w_sp_ok) begin
                    n_res.error = ERR_PTR;
                end else begin
                    w_ctl.push            = r_cmd_vld;
                    n_res.dma_issue       = 1'b1;
                    n_res.dma_to_memory   = 1'b1;
                    n_res.dma_local_addr  = r_cmd.stack_pointer;
                    n_res.dma_global_addr = w_glob;
                    n_res.dma_length      = w_len;
                end
            end
            ACT_RESTORE: begin
                if (w_sts.empty) begin
                    n_res.error = ERR_EMPTY;
                end else begin
                    w_ctl.pop             = r_cmd_vld;
                    n_res.dma_issue       = 1'b1;
                    n_res.dma_local_addr  = w_sts.top.local_addr;
                    n_res.dma_global_addr = w_sts.top.global_addr;
                    n_res.dma_length      = w_sts.top.length;
                end
            end
            ACT_L2G: begin
                n_res.result_addr = r_cmd.address;
                if (w_sp_ok && (r_cmd.address >= r_cmd.stack_pointer) &&
                    (r_cmd.address < r_spm_base)) begin
                    n_res.result_addr = w_top - w_l_off;
                    n_res.translated  = 1'b1;
                end
            end
            ACT_G2L: begin
                n_res.result_addr = r_cmd.address;
                // distance from the top is compared, so no wrap below zero
                if (w_sp_ok && (r_cmd.address < w_top) && (w_g_off <= w_len)) begin
                    n_res.result_addr = r_spm_base - w_g_off;
                    n_res.translated  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= r_cmd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid  = r_res_vld;
    assign o_result = r_res;

`ifndef ASSERT_OFF
    a_two_cycle_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_valid)
        else $error("accepted transaction did not produce a result");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.error != ERR_OK) |->
        (!o_result.dma_issue && !o_result.translated))
        else $error("error result carries a command or translation");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.count <= CNT_W'(MAX_FRAMES))
        else $error("frame count beyond table depth");

    a_push_moves_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.push |=> (w_sts.count == $past(w_sts.count) + CNT_W'(1)))
        else $error("push did not advance frame count");
`endif

endmodule

@@ tb/sv/tb_scratchpad_stack_frame_manager.sv @@
`timescale 1ns / 1ps

module tb_scratchpad_stack_frame_manager;

    import ssfm_pkg::*;

    localparam logic [2:0] SPM_BASE_ADDR = {REG_SPM_BASE, 2'b00};
    localparam logic [2:0] MEM_BASE_ADDR = {REG_MEM_BASE, 2'b00};
    localparam int         DRAIN_CYCLES  = 6;
    localparam int         PHASE_ITEMS   = 265;
    localparam int         REPORT_LIMIT  = 10;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_cmd        i_cmd   = '0;
    logic        o_valid;
    t_result     o_result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    scratchpad_stack_frame_manager DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 i_clk = ~i_clk;

    // register copies, shared by the frame predictor and the command generator
    logic [ADDR_W-1:0] spm_base_q = '0;
    logic [ADDR_W-1:0] mem_base_q = '0;

    // predicted frame stack
    logic [ADDR_W-1:0] stack_laddr [MAX_FRAMES];
    logic [ADDR_W-1:0] stack_gaddr [MAX_FRAMES];
    logic [ADDR_W-1:0] stack_len   [MAX_FRAMES];
    int                stack_depth = 0;

    // generator view of the frame tops, used to aim translations at live ranges
    logic [ADDR_W-1:0] gen_tops [$];
    logic [ADDR_W-1:0] live_sp = '0;

    t_cmd    pending_cmds     [$];
    t_result expected_results [$];
    int      sender_idle_pct  = 0;
    int      mismatch_count   = 0;
    int      item_total       = 0;
    logic    cmd_taken;

    function automatic t_result predict_frame_action(input t_cmd c);
        t_result           r;
        logic [ADDR_W-1:0] top;
        logic [ADDR_W-1:0] len;
        logic [ADDR_W-1:0] gaddr;
        r = '0;
        top = (stack_depth == 0) ? mem_base_q : stack_gaddr[stack_depth-1];
        case (c.action)
            ACT_EVICT: begin
                if (stack_depth >= MAX_FRAMES) begin
                    r.error = ERR_FULL;
                end else if (c.stack_pointer > spm_base_q) begin
                    r.error = ERR_PTR;
                end else begin
                    len   = spm_base_q - c.stack_pointer;
                    gaddr = top - len;
                    stack_laddr[stack_depth] = c.stack_pointer;
                    stack_gaddr[stack_depth] = gaddr;
                    stack_len[stack_depth]   = len;
                    stack_depth++;
                    r.dma_issue       = 1'b1;
                    r.dma_to_memory   = 1'b1;
                    r.dma_local_addr  = c.stack_pointer;
                    r.dma_global_addr = gaddr;
                    r.dma_length      = len;
                end
            end
            ACT_RESTORE: begin
                if (stack_depth == 0) begin
                    r.error = ERR_EMPTY;
                end else begin
                    stack_depth--;
                    r.dma_issue       = 1'b1;
                    r.dma_to_memory   = 1'b0;
                    r.dma_local_addr  = stack_laddr[stack_depth];
                    r.dma_global_addr = stack_gaddr[stack_depth];
                    r.dma_length      = stack_len[stack_depth];
                end
            end
            ACT_L2G: begin
                r.result_addr = c.address;
                if (c.stack_pointer <= spm_base_q && c.address >= c.stack_pointer &&
                    c.address < spm_base_q) begin
                    r.result_addr = top - (spm_base_q - c.address);
                    r.translated  = 1'b1;
                end
            end
            ACT_G2L: begin
                r.result_addr = c.address;
                // written without wrap: below top, and distance within frame length
                if (c.stack_pointer <= spm_base_q && c.address < top &&
                    (top - c.address) <= (spm_base_q - c.stack_pointer)) begin
                    r.result_addr = spm_base_q - (top - c.address);
                    r.translated  = 1'b1;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void log_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("[%0t] mismatch %0d: %s", $time, mismatch_count, msg);
    endfunction

    function automatic void check_result(input t_result exp, input t_result act);
        string bad;
        bad = "";
        if (act.dma_issue !== exp.dma_issue)             bad = {bad, " dma_issue"};
        if (act.dma_to_memory !== exp.dma_to_memory)     bad = {bad, " dma_to_memory"};
        if (act.dma_local_addr !== exp.dma_local_addr)   bad = {bad, " dma_local_addr"};
        if (act.dma_global_addr !== exp.dma_global_addr) bad = {bad, " dma_global_addr"};
        if (act.dma_length !== exp.dma_length)           bad = {bad, " dma_length"};
        if (act.result_addr !== exp.result_addr)         bad = {bad, " result_addr"};
        if (act.translated !== exp.translated)           bad = {bad, " translated"};
        if (act.error !== exp.error)                     bad = {bad, " error"};
        if (bad != "")
            log_failure($sformatf("fields%s exp=%p act=%p", bad, exp, act));
    endfunction

    // driver: one command transaction per accepting edge, random gaps between
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            cmd_taken = start && !busy;
            if (cmd_taken)
                expected_results.push_back(predict_frame_action(i_cmd));
            if (cmd_taken || !start) begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    start <= 1'b1;
                    i_cmd <= pending_cmds.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: results are strobed for a single cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (expected_results.size() == 0)
                log_failure($sformatf("result with no command outstanding: %p", o_result));
            else
                check_result(expected_results.pop_front(), o_result);
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == SPM_BASE_ADDR)
            spm_base_q = data;
        else if (addr == MEM_BASE_ADDR)
            mem_base_q = data;
    endtask

    task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] exp);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== exp)
            log_failure($sformatf("register read at %0d exp=%h act=%h", addr, exp, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_bases(input logic [31:0] spm, input logic [31:0] mem);
        apb_write(SPM_BASE_ADDR, spm);
        apb_write(MEM_BASE_ADDR, mem);
        apb_read_check(SPM_BASE_ADDR, spm);
        apb_read_check(MEM_BASE_ADDR, mem);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || start || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [ADDR_W-1:0] gen_top();
        return (gen_tops.size() == 0) ? mem_base_q : gen_tops[$];
    endfunction

    function automatic void sync_gen_stack();
        gen_tops.delete();
        for (int i = 0; i < stack_depth; i++)
            gen_tops.push_back(stack_gaddr[i]);
    endfunction

    function automatic void queue_cmd(input logic [1:0] act, input logic [ADDR_W-1:0] sp,
                                      input logic [ADDR_W-1:0] addr);
        t_cmd c;
        c.action        = act;
        c.stack_pointer = sp;
        c.address       = addr;
        pending_cmds.push_back(c);
        if (act == ACT_EVICT && gen_tops.size() < MAX_FRAMES && sp <= spm_base_q)
            gen_tops.push_back(gen_top() - (spm_base_q - sp));
        else if (act == ACT_RESTORE && gen_tops.size() != 0)
            void'(gen_tops.pop_back());
        item_total++;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_frame_sp();
        logic [ADDR_W-1:0] len;
        // occasionally a pointer above the base
        if ($urandom_range(19) == 0 && spm_base_q != '1)
            return spm_base_q + 1 + $urandom_range(255);
        case ($urandom_range(9))
            0:       len = spm_base_q;
            1:       len = $urandom_range(spm_base_q);
            2:       len = '0;
            default: len = $urandom_range(2048);
        endcase
        if (len > spm_base_q)
            len = spm_base_q;
        return spm_base_q - len;
    endfunction

    // lo inclusive, hi exclusive
    function automatic logic [ADDR_W-1:0] pick_window_addr(input logic [ADDR_W-1:0] lo,
                                                           input logic [ADDR_W-1:0] hi);
        logic [ADDR_W-1:0] w;
        w = hi - lo;
        case ($urandom_range(9))
            0:       return lo;
            1:       return hi - 1;
            2:       return hi;
            3:       return lo - 1;
            4:       return $urandom();
            default: return (w == 0) ? lo : lo + $urandom_range(w - 1);
        endcase
    endfunction

    function automatic void queue_evict();
        queue_cmd(ACT_EVICT, pick_frame_sp(), $urandom());
        live_sp = pick_frame_sp();
    endfunction

    function automatic void queue_restore();
        queue_cmd(ACT_RESTORE, $urandom(), $urandom());
    endfunction

    function automatic void queue_translate();
        logic [ADDR_W-1:0] sp;
        logic [ADDR_W-1:0] lo;
        logic [ADDR_W-1:0] hi;
        logic [1:0]        act;
        act = $urandom_range(1) ? ACT_G2L : ACT_L2G;
        case ($urandom_range(9))
            0:       sp = spm_base_q + 1;
            1:       sp = $urandom();
            default: sp = live_sp;
        endcase
        if (act == ACT_L2G) begin
            lo = sp;
            hi = spm_base_q;
        end else begin
            hi = gen_top();
            lo = hi - (spm_base_q - sp);
        end
        queue_cmd(act, sp, pick_window_addr(lo, hi));
    endfunction

    function automatic void queue_some_translates(input int max_n);
        int n;
        n = $urandom_range(max_n);
        repeat (n) queue_translate();
    endfunction

    task automatic run_phase(input logic [31:0] spm, input logic [31:0] mem, input int idle);
        int target;
        int k;
        set_bases(spm, mem);
        sync_gen_stack();
        live_sp = pick_frame_sp();
        sender_idle_pct = idle;
        target = item_total + PHASE_ITEMS;
        while (item_total < target) begin
            k = $urandom_range(99);
            if (k < 45) begin
                // call chain: nested evicts, then unwind, sometimes one restore too many
                k = $urandom_range(1, 6);
                repeat (k) begin
                    queue_evict();
                    queue_some_translates(3);
                end
                if ($urandom_range(7) == 0)
                    k++;
                repeat (k) begin
                    queue_restore();
                    queue_some_translates(2);
                end
            end else if (k < 60) begin
                // MAX_FRAMES to MAX_FRAMES+3 evicts toward or past full, then as many restores
                k = MAX_FRAMES + $urandom_range(3);
                repeat (k) begin
                    queue_evict();
                    if ($urandom_range(3) == 0)
                        queue_translate();
                end
                repeat (k) begin
                    queue_restore();
                    if ($urandom_range(3) == 0)
                        queue_translate();
                end
            end else if (k < 85) begin
                repeat ($urandom_range(4, 8)) queue_translate();
            end else begin
                repeat ($urandom_range(1, 4))
                    queue_cmd(2'($urandom_range(3)), $urandom(), $urandom());
            end
        end
        wait_drained();
    endtask

    task automatic run_directed();
        logic [ADDR_W-1:0] top;
        set_bases(32'h0000_8000, 32'h8000_0000);
        sync_gen_stack();
        sender_idle_pct = 0;
        queue_cmd(ACT_RESTORE, 32'h0, 32'h0);                 // empty stack
        queue_cmd(ACT_L2G, 32'h0000_7000, 32'h0000_7800);     // maps below the memory base
        queue_cmd(ACT_G2L, 32'h0000_7000, 32'h7FFF_FFFF);
        queue_cmd(ACT_EVICT, 32'h0000_8001, 32'hFFFF_FFFF);   // pointer above base
        queue_cmd(ACT_EVICT, 32'h0000_8000, 32'h0);           // zero-length frame
        queue_cmd(ACT_EVICT, 32'h0, 32'h0);                   // longest frame
        queue_cmd(ACT_EVICT, 32'h0000_7F00, 32'h0);
        queue_cmd(ACT_L2G, 32'h0000_7F00, 32'h0000_7F00);
        queue_cmd(ACT_L2G, 32'h0000_7F00, 32'h0000_7FFF);
        queue_cmd(ACT_L2G, 32'h0000_7F00, 32'h0000_8000);
        queue_cmd(ACT_L2G, 32'h0000_7F00, 32'h0000_7EFF);
        queue_cmd(ACT_L2G, 32'h0000_8001, 32'h0000_7F80);     // empty live range
        top = gen_top();
        queue_cmd(ACT_G2L, 32'h0000_7F00, top - 1);
        queue_cmd(ACT_G2L, 32'h0000_7F00, top - 32'h100);
        queue_cmd(ACT_G2L, 32'h0000_7F00, top - 32'h101);
        queue_cmd(ACT_G2L, 32'h0000_7F00, top);
        queue_cmd(ACT_G2L, 32'hFFFF_FFFF, top - 1);
        queue_cmd(ACT_G2L, 32'h0000_7F00, 32'h0);
        queue_cmd(ACT_L2G, 32'h0, 32'hFFFF_FFFF);
        repeat (4) queue_cmd(ACT_RESTORE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_phase(32'h0001_0000, 32'h8000_0000, 0);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 56);
        run_phase(32'h0000_0000, 32'h0000_0000, 7);
        run_phase($urandom(), $urandom(), 56);
        // memory base below the frame sizes, so global addresses wrap
        run_phase(32'h0000_4000, 32'h0000_1000, 0);
        run_phase($urandom(), $urandom(), 7);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
